// ----- hw/rtl/mpsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_pkg: shared types and constants of the motor PI speed controller
// Fixed field widths, loop constants, command and register codes, and the
// structs that pass between the encoder counter, sequencer and top level.
// ----------------------------------------------------------------------------
package mpsc_pkg;

  // loop constants
  localparam int unsigned PWM_STEPS = 240;
  localparam int unsigned TOP_RPM   = 350;
  localparam int unsigned ADC_BITS  = 12;

  // field widths
  localparam int unsigned POT_W      = 12;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned MEAS_RPM_W = 12;
  localparam int unsigned TGT_RPM_W  = 9;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned RPP_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  // config reset values
  localparam logic              CLOSED_LOOP_RST = 1'b0;
  localparam logic              TURN_DIR_RST    = 1'b1;
  localparam logic [GAIN_W-1:0] P_GAIN_RST      = 8'd12;
  localparam logic [GAIN_W-1:0] I_GAIN_RST      = 8'd30;
  localparam logic [RPP_W-1:0]  RPP_RST         = 16'd1369;

  // shared multiplier: signed a times unsigned b
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W + 1;

  // PI datapath widths
  localparam int unsigned E_W     = 26;  // speed error, rpm q8, +-2^24
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned KP_W    = 23;  // p_gain * 100 * PWM_STEPS
  localparam int unsigned KI_W    = 16;  // i_gain * PWM_STEPS
  localparam int unsigned NUM_W   = 49;  // signed PI numerator
  localparam int unsigned REM_W   = 48;  // rounded numerator

  localparam longint unsigned ERR_LIMIT    = 64'd16777216;
  localparam longint unsigned ERR_MEAS_CAP = 2 * ERR_LIMIT;
  localparam longint unsigned DEN          = 64'd256000 * TOP_RPM;
  localparam longint unsigned HALF_DEN     = DEN / 2;
  localparam longint unsigned SAT_DEN      = DEN * PWM_STEPS;
  localparam int unsigned     KP_SCALE     = 100 * PWM_STEPS;

  // divide by DEN: drop its 2^12 factor, then multiply by the reciprocal of
  // the odd part; exact for every numerator below SAT_DEN
  localparam int unsigned     DEN_SHIFT   = 12;
  localparam longint unsigned DEN_ODD     = DEN >> DEN_SHIFT;
  localparam int unsigned     RECIP_SHIFT = 38;
  localparam longint unsigned RECIP       = ((64'd1 << RECIP_SHIFT) + DEN_ODD - 1) / DEN_ODD;

  typedef enum logic [IN_USER_W-1:0] {
    CMD_EDGE_A = 2'd0,
    CMD_EDGE_B = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_STEP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOSED_LOOP   = 3'd0,
    REG_TURN_DIR      = 3'd1,
    REG_P_GAIN        = 3'd2,
    REG_I_GAIN        = 3'd3,
    REG_RPM_PER_PULSE = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAS,
    ST_TGT,
    ST_OL,
    ST_CAP,
    ST_ERR,
    ST_INTEG,
    ST_KI,
    ST_PE,
    ST_IE,
    ST_RND,
    ST_CHK,
    ST_DIV,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic              closed_loop;
    logic [GAIN_W-1:0] p_gain;
    logic [GAIN_W-1:0] i_gain;
    logic [RPP_W-1:0]  rpm_per_pulse;
  } ctrl_cfg_t;

  typedef struct packed {
    logic inc_a;
    logic inc_b;
    logic tick;
    logic consume;
  } enc_ctrl_t;

  typedef struct packed {
    logic idle;
    logic consume;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    logic [TGT_RPM_W-1:0]  target_rpm;
    logic [MEAS_RPM_W-1:0] measured_rpm;
    logic [DUTY_W-1:0]     duty;
  } ctrl_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/motor_pi_speed_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_pi_speed_control: encoder counting and PI motor speed loop
// Counts encoder edges per PWM period and sets the PWM duty from the pot in
// open loop or through a PI law in closed loop.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      content
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser cmd, tdata pot sample
//  m_axis    out        m_axis_tvalid / m_axis_tready  duty, drive pins, rpm values
//  cfg       in         cfg_valid_i / cfg_ready_o      register index and data
//
// edges, period ticks and a control step with no pending period do not start the
// sequencer. a control step with a pending period walks it through its states,
// in closed loop with up to eight passes through the shared multiplier, the last a
// reciprocal multiply for the rounded duty. s_axis is not ready meanwhile.
// a finished result waits in the m_axis register; the sequencer holds its
// last state until that register is free. reset gives the config registers defaults.
// ----------------------------------------------------------------------------
module motor_pi_speed_control #(
  parameter int unsigned EDGE_COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [11:0] pot_sample
  input  logic [mpsc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] cmd
  input  logic [mpsc_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] duty, [8] drive_a, [9] drive_b, [21:10] measured_rpm, [30:22] target_rpm
  output logic [mpsc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mpsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mpsc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mpsc_pkg::*;

  ctrl_cfg_t    cfg_q;
  logic         turn_dir_q;
  logic         m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic         in_acc;
  cmd_e         cmd;
  enc_ctrl_t    enc_ctrl;
  seq_stat_t    seq_stat;
  ctrl_result_t result;
  logic [EDGE_COUNT_BITS:0] pulses;
  logic         pending;
  logic         out_free;
  logic         start;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign s_axis_tready = seq_stat.idle;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign start         = in_acc && (cmd == CMD_STEP) && pending;

  always_comb begin
    enc_ctrl.inc_a   = in_acc && (cmd == CMD_EDGE_A);
    enc_ctrl.inc_b   = in_acc && (cmd == CMD_EDGE_B);
    enc_ctrl.tick    = in_acc && (cmd == CMD_TICK);
    enc_ctrl.consume = seq_stat.consume;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.closed_loop   <= CLOSED_LOOP_RST;
      cfg_q.p_gain        <= P_GAIN_RST;
      cfg_q.i_gain        <= I_GAIN_RST;
      cfg_q.rpm_per_pulse <= RPP_RST;
      turn_dir_q          <= TURN_DIR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CLOSED_LOOP:   cfg_q.closed_loop   <= cfg_data_i[0];
        REG_TURN_DIR:      turn_dir_q          <= cfg_data_i[0];
        REG_P_GAIN:        cfg_q.p_gain        <= cfg_data_i[GAIN_W-1:0];
        REG_I_GAIN:        cfg_q.i_gain        <= cfg_data_i[GAIN_W-1:0];
        REG_RPM_PER_PULSE: cfg_q.rpm_per_pulse <= cfg_data_i[RPP_W-1:0];
        default:           turn_dir_q          <= turn_dir_q;
      endcase
    end
  end

  mpsc_enc #(
    .EDGE_COUNT_BITS (EDGE_COUNT_BITS)
  ) u_enc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (enc_ctrl),
    .pulses_o  (pulses),
    .pending_o (pending)
  );

  mpsc_seq #(
    .PULSE_W (EDGE_COUNT_BITS + 1)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .cfg_i      (cfg_q),
    .pot_i      (s_axis_tdata[POT_W-1:0]),
    .pulses_i   (pulses),
    .stat_o     (seq_stat),
    .result_o   (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (seq_stat.done && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_stat.done && out_free) begin
      m_data_q <= OUT_DATA_W'({result.target_rpm, result.measured_rpm,
                               ~turn_dir_q, turn_dir_q, result.duty});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mpsc_enc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_enc: encoder edge counters and period latch
// Two saturating edge counters; a period tick latches their sum, clears them
// and marks the period pending until the sequencer consumes it.
// ----------------------------------------------------------------------------
module mpsc_enc #(
  parameter int unsigned EDGE_COUNT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mpsc_pkg::enc_ctrl_t      ctrl_i,
  output logic [EDGE_COUNT_BITS:0] pulses_o,
  output logic                     pending_o
);
  import mpsc_pkg::*;

  logic [EDGE_COUNT_BITS-1:0] edges_a_q;
  logic [EDGE_COUNT_BITS-1:0] edges_b_q;
  logic [EDGE_COUNT_BITS:0]   pulses_q;
  logic                       pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_a_q <= '0;
      edges_b_q <= '0;
      pulses_q  <= '0;
      pending_q <= 1'b0;
    end else begin
      if (ctrl_i.tick) begin
        pulses_q  <= {1'b0, edges_a_q} + {1'b0, edges_b_q};
        edges_a_q <= '0;
        edges_b_q <= '0;
        pending_q <= 1'b1;
      end else begin
        // counters hold at full scale
        if (ctrl_i.inc_a && (edges_a_q != '1)) begin
          edges_a_q <= edges_a_q + 1'b1;
        end
        if (ctrl_i.inc_b && (edges_b_q != '1)) begin
          edges_b_q <= edges_b_q + 1'b1;
        end
        if (ctrl_i.consume) begin
          pulses_q  <= '0;
          pending_q <= 1'b0;
        end
      end
    end
  end

  assign pulses_o  = pulses_q;
  assign pending_o = pending_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mpsc_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_mul: shared registered multiplier
// Signed a operand times unsigned b operand, product registered.
// ----------------------------------------------------------------------------
module mpsc_mul (
  input  logic                                 clk_i,
  input  logic signed [mpsc_pkg::MUL_A_W-1:0]  a_i,
  input  logic        [mpsc_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [mpsc_pkg::MUL_P_W-1:0]  p_o
);
  import mpsc_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * $signed({1'b0, b_i});
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ----- hw/rtl/mpsc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_seq: control step sequencer
// Walks one control step through the shared multiplier: measured and target
// speed, open loop duty, then error, integral, PI sum and a rounded
// reciprocal-multiply divide for the closed loop duty.
// ----------------------------------------------------------------------------
module mpsc_seq #(
  parameter int unsigned PULSE_W = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       out_free_i,
  input  mpsc_pkg::ctrl_cfg_t        cfg_i,
  input  logic [mpsc_pkg::POT_W-1:0] pot_i,
  input  logic [PULSE_W-1:0]         pulses_i,
  output mpsc_pkg::seq_stat_t        stat_o,
  output mpsc_pkg::ctrl_result_t     result_o
);
  import mpsc_pkg::*;

  localparam int unsigned MEAS_W   = PULSE_W + RPP_W;
  localparam int unsigned MQ_W     = (MEAS_W > E_W + 1) ? MEAS_W : E_W + 1;
  localparam int unsigned TRAW_W   = POT_W + $clog2(TOP_RPM + 1);
  localparam int unsigned OL_W     = POT_W + $clog2(PWM_STEPS + 1);
  localparam int unsigned OLD_W    = OL_W - ADC_BITS;
  localparam int unsigned MW_W     = MEAS_W - 8;
  localparam int unsigned Q8_SHIFT = ADC_BITS - 8;
  localparam logic signed [E_W+1:0] ERR_HI = (E_W + 2)'(ERR_LIMIT);
  localparam logic signed [E_W+1:0] ERR_LO = -ERR_HI;

  seq_state_e state_q, state_d;

  logic        [POT_W-1:0]     pot_q;
  logic        [MEAS_W-1:0]    meas_q;
  logic        [TRAW_W-1:0]    traw_q;
  logic        [DUTY_W-1:0]    duty_q;
  logic signed [E_W-1:0]       e_q;
  logic signed [INTEG_W-1:0]   integ_q;
  logic        [KP_W-1:0]      kp_q;
  logic        [KI_W-1:0]      ki_q;
  logic signed [NUM_W-1:0]     acc_q;
  logic        [REM_W-1:0]     rem_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic        [TRAW_W-1:0]  tgt_q8;
  logic        [MQ_W-1:0]    meas_ext;
  logic        [E_W:0]       mq_cap;
  logic signed [E_W+1:0]     err_diff;
  logic signed [E_W+1:0]     err_clamp;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic        [OLD_W-1:0]   ol_duty;
  logic                      acc_nonpos;
  logic        [MW_W-1:0]    meas_whole;

  mpsc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_MEAS;
      ST_MEAS:  state_d = ST_TGT;
      ST_TGT:   state_d = ST_OL;
      ST_OL:    state_d = ST_CAP;
      ST_CAP:   state_d = cfg_i.closed_loop ? ST_ERR : ST_OUT;
      ST_ERR:   state_d = ST_INTEG;
      ST_INTEG: state_d = ST_KI;
      ST_KI:    state_d = ST_PE;
      ST_PE:    state_d = ST_IE;
      ST_IE:    state_d = ST_RND;
      ST_RND:   state_d = acc_nonpos ? ST_OUT : ST_CHK;
      ST_CHK:   state_d = (rem_q >= REM_W'(SAT_DEN)) ? ST_OUT : ST_DIV;
      ST_DIV:   state_d = ST_OUT;
      ST_OUT:   if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs: multiplier operands and status
  always_comb begin
    mul_a          = '0;
    mul_b          = '0;
    stat_o.idle    = 1'b0;
    stat_o.consume = 1'b0;
    stat_o.done    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        stat_o.idle = 1'b1;
      end
      ST_MEAS: begin
        mul_a          = MUL_A_W'(pulses_i);
        mul_b          = MUL_B_W'(cfg_i.rpm_per_pulse);
        stat_o.consume = 1'b1;
      end
      ST_TGT: begin
        mul_a = MUL_A_W'(pot_q);
        mul_b = MUL_B_W'(TOP_RPM);
      end
      ST_OL: begin
        mul_a = MUL_A_W'(pot_q);
        mul_b = MUL_B_W'(PWM_STEPS);
      end
      ST_ERR: begin
        mul_a = MUL_A_W'(KP_SCALE);
        mul_b = MUL_B_W'(cfg_i.p_gain);
      end
      ST_INTEG: begin
        mul_a = MUL_A_W'(PWM_STEPS);
        mul_b = MUL_B_W'(cfg_i.i_gain);
      end
      ST_KI: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = MUL_B_W'(kp_q);
      end
      ST_PE: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = MUL_B_W'(ki_q);
      end
      ST_CHK: begin
        // quotient by DEN through the reciprocal of its odd part
        mul_a = MUL_A_W'(rem_q >> DEN_SHIFT);
        mul_b = MUL_B_W'(RECIP);
      end
      ST_OUT: begin
        stat_o.done = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // speed error, measured side capped before the subtract
  always_comb begin
    tgt_q8   = traw_q >> Q8_SHIFT;
    meas_ext = MQ_W'(meas_q);
    mq_cap   = (meas_ext > MQ_W'(ERR_MEAS_CAP)) ? (E_W + 1)'(ERR_MEAS_CAP)
                                                : meas_ext[E_W:0];
    err_diff = $signed((E_W + 2)'(tgt_q8)) - $signed((E_W + 2)'(mq_cap));
    if (err_diff > ERR_HI) begin
      err_clamp = ERR_HI;
    end else if (err_diff < ERR_LO) begin
      err_clamp = ERR_LO;
    end else begin
      err_clamp = err_diff;
    end
  end

  // integral accumulate with signed saturation
  always_comb begin
    integ_sum = (INTEG_W + 1)'(integ_q) + (INTEG_W + 1)'(e_q);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                     : {1'b0, {(INTEG_W - 1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  always_comb begin
    ol_duty    = mul_p[OL_W-1:ADC_BITS];
    acc_nonpos = acc_q[NUM_W-1] || (acc_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      integ_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INTEG) begin
        integ_q <= integ_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          pot_q <= POT_W'(pot_i[ADC_BITS-1:0]);
        end
      end
      ST_TGT: begin
        meas_q <= mul_p[MEAS_W-1:0];
      end
      ST_OL: begin
        traw_q <= mul_p[TRAW_W-1:0];
      end
      ST_CAP: begin
        duty_q <= (ol_duty > OLD_W'(PWM_STEPS)) ? DUTY_W'(PWM_STEPS) : DUTY_W'(ol_duty);
      end
      ST_ERR: begin
        e_q <= E_W'(err_clamp);
      end
      ST_INTEG: begin
        kp_q <= mul_p[KP_W-1:0];
      end
      ST_KI: begin
        ki_q <= mul_p[KI_W-1:0];
      end
      ST_PE: begin
        acc_q <= mul_p[NUM_W-1:0];
      end
      ST_IE: begin
        acc_q <= acc_q + mul_p[NUM_W-1:0];
      end
      ST_RND: begin
        // round half away from zero: the sum is used only for a positive numerator
        rem_q <= REM_W'(acc_q) + REM_W'(HALF_DEN);
        if (acc_nonpos) begin
          duty_q <= '0;
        end
      end
      ST_CHK: begin
        if (rem_q >= REM_W'(SAT_DEN)) begin
          duty_q <= DUTY_W'(PWM_STEPS);
        end
      end
      ST_DIV: begin
        duty_q <= mul_p[RECIP_SHIFT +: DUTY_W];
      end
      default: begin
        duty_q <= duty_q;
      end
    endcase
  end

  always_comb begin
    meas_whole            = meas_q[MEAS_W-1:8];
    result_o.duty         = duty_q;
    result_o.measured_rpm = (meas_whole > MW_W'({MEAS_RPM_W{1'b1}})) ? {MEAS_RPM_W{1'b1}}
                                                                     : MEAS_RPM_W'(meas_whole);
    result_o.target_rpm   = TGT_RPM_W'(traw_q >> ADC_BITS);
  end

endmodule
`default_nettype wire

// ----- sim/speed_loop_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_loop_checker: predicts and scores the speed controller reports
// Watches the input, register and report channels of the speed controller,
// keeps its own copy of the encoder counters, the PI integral and the
// registers, and compares each report field by field in order of arrival.
// ----------------------------------------------------------------------------
module speed_loop_checker #(
  parameter int unsigned EDGE_COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // [11:0] pot_sample
  input  logic [mpsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [mpsc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] duty, [8] drive_a, [9] drive_b, [21:10] measured_rpm, [30:22] target_rpm
  input  logic [mpsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [mpsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mpsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     mismatches,
  output int unsigned                     open_reports,
  output int unsigned                     reports_checked
);
  import mpsc_pkg::*;

  localparam longint PWM_L     = PWM_STEPS;
  localparam longint TOP_L     = TOP_RPM;
  localparam longint ERR_LIM   = 64'sd16777216;
  localparam longint INTEG_HI  = 64'sd2147483647;
  localparam longint INTEG_LO  = -64'sd2147483648;
  localparam longint PI_DEN    = 64'sd256000 * TOP_L;
  localparam longint MEAS_MAX  = (1 << MEAS_RPM_W) - 1;
  localparam longint TGT_MAX   = (1 << TGT_RPM_W) - 1;

  typedef struct packed {
    logic                  pad;
    logic [TGT_RPM_W-1:0]  target_rpm;
    logic [MEAS_RPM_W-1:0] measured_rpm;
    logic                  drive_b;
    logic                  drive_a;
    logic [DUTY_W-1:0]     duty;
  } speed_report_t;

  speed_report_t speed_reports[$];

  // register copy
  logic              loop_closed;
  logic              ccw;
  logic [GAIN_W-1:0] kp_steps;
  logic [GAIN_W-1:0] ki_steps;
  logic [RPP_W-1:0]  rpm_q8_per_pulse;

  // controller state copy
  logic [EDGE_COUNT_BITS-1:0] count_a;
  logic [EDGE_COUNT_BITS-1:0] count_b;
  logic [EDGE_COUNT_BITS:0]   latched_pulses;
  logic                       period_ready;
  longint                     integ_q8;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    speed_report_t got;
    speed_report_t want;
    longint        pot;
    longint        meas_q8;
    longint        target_q8;
    longint        err;
    longint        num;
    longint        duty_l;
    if (!rst_ni) begin
      speed_reports.delete();
      loop_closed      = CLOSED_LOOP_RST;
      ccw              = TURN_DIR_RST;
      kp_steps         = P_GAIN_RST;
      ki_steps         = I_GAIN_RST;
      rpm_q8_per_pulse = RPP_RST;
      count_a          = '0;
      count_b          = '0;
      latched_pulses   = '0;
      period_ready     = 1'b0;
      integ_q8         = 0;
      mismatches       = 0;
      reports_checked  = 0;
      open_reports    <= 0;
    end else begin
      // a report leaves before a new input can add one in the same cycle
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        reports_checked++;
        if (speed_reports.size() == 0) begin
          $error("report transaction with nothing outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = speed_reports.pop_front();
          if (got.duty !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, got.duty);
            mismatches++;
          end
          if (got.drive_a !== want.drive_a) begin
            $error("drive_a: expected %0d, actual %0d", want.drive_a, got.drive_a);
            mismatches++;
          end
          if (got.drive_b !== want.drive_b) begin
            $error("drive_b: expected %0d, actual %0d", want.drive_b, got.drive_b);
            mismatches++;
          end
          if (got.measured_rpm !== want.measured_rpm) begin
            $error("measured_rpm: expected %0d, actual %0d",
                   want.measured_rpm, got.measured_rpm);
            mismatches++;
          end
          if (got.target_rpm !== want.target_rpm) begin
            $error("target_rpm: expected %0d, actual %0d", want.target_rpm, got.target_rpm);
            mismatches++;
          end
          if (got.pad !== want.pad) begin
            $error("tdata padding: expected %0d, actual %0d", want.pad, got.pad);
            mismatches++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_CLOSED_LOOP:   loop_closed      = cfg_data_i[0];
          REG_TURN_DIR:      ccw              = cfg_data_i[0];
          REG_P_GAIN:        kp_steps         = cfg_data_i[GAIN_W-1:0];
          REG_I_GAIN:        ki_steps         = cfg_data_i[GAIN_W-1:0];
          REG_RPM_PER_PULSE: rpm_q8_per_pulse = cfg_data_i[RPP_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          CMD_EDGE_A: if (count_a != '1) count_a = count_a + 1'b1;
          CMD_EDGE_B: if (count_b != '1) count_b = count_b + 1'b1;
          CMD_TICK: begin
            latched_pulses = {1'b0, count_a} + {1'b0, count_b};
            count_a        = '0;
            count_b        = '0;
            period_ready   = 1'b1;
          end
          default: begin
            if (period_ready) begin
              pot       = longint'(s_axis_tdata[ADC_BITS-1:0]);
              meas_q8   = longint'(latched_pulses) * longint'(rpm_q8_per_pulse);
              target_q8 = (pot * TOP_L * 256) >>> ADC_BITS;
              if (!loop_closed) begin
                duty_l = (pot * PWM_L) >>> ADC_BITS;
              end else begin
                // measured speed is capped before the error is formed
                err = target_q8 - ((meas_q8 > 2 * ERR_LIM) ? 2 * ERR_LIM : meas_q8);
                if (err > ERR_LIM) err = ERR_LIM;
                if (err < -ERR_LIM) err = -ERR_LIM;
                integ_q8 = integ_q8 + err;
                if (integ_q8 > INTEG_HI) integ_q8 = INTEG_HI;
                if (integ_q8 < INTEG_LO) integ_q8 = INTEG_LO;
                num = (longint'(kp_steps) * 100 * err + longint'(ki_steps) * integ_q8) * PWM_L;
                duty_l = (num <= 0) ? 0 : (num + PI_DEN / 2) / PI_DEN;
              end
              if (duty_l > PWM_L) duty_l = PWM_L;
              want.pad          = 1'b0;
              want.duty         = duty_l[DUTY_W-1:0];
              want.drive_a      = ccw;
              want.drive_b      = ~ccw;
              want.measured_rpm = ((meas_q8 >>> 8) > MEAS_MAX) ? MEAS_MAX[MEAS_RPM_W-1:0]
                                                                : meas_q8[8 +: MEAS_RPM_W];
              want.target_rpm   = ((pot * TOP_L) >>> ADC_BITS > TGT_MAX) ?
                                  TGT_MAX[TGT_RPM_W-1:0] :
                                  TGT_RPM_W'((pot * TOP_L) >>> ADC_BITS);
              speed_reports.push_back(want);
              latched_pulses = '0;
              period_ready   = 1'b0;
            end
          end
        endcase
      end

      open_reports <= speed_reports.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the motor PI speed controller
// Drives encoder edges, period ticks and control steps in bursts against a
// receiver that stalls on its own pattern, reprograms the registers between
// phases, and drives one period hard enough to clamp the speed error.
// ----------------------------------------------------------------------------
module testbench;
  import mpsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT        = 2_000_000;
  localparam int unsigned LONG_HOLD          = 400;
  localparam int unsigned DRAIN_CYCLES       = 40;
  localparam int unsigned RANDOM_ITEMS       = 400;
  localparam int unsigned PHASE_ITEMS        = 100;
  localparam int unsigned EDGES_PER_BIG_ERR  = 260;
  localparam int unsigned REG_UNUSED_LO      = int'(REG_RPM_PER_PULSE) + 1;
  localparam int unsigned REG_UNUSED_HI      = (1 << CFG_IDX_W) - 1;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_BUSY,
    RX_CONGESTED,
    RX_PATTERN
  } rx_mode_e;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = CMD_EDGE_A;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_CLOSED_LOOP;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned mismatches;
  int unsigned open_reports;
  int unsigned reports_checked;

  int unsigned burst_left    = 0;
  bit          no_gaps       = 1'b0;
  bit          period_open   = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned reports_due   = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycles        = 0;

  always #10 clk_i = ~clk_i;

  motor_pi_speed_control dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  speed_loop_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatches      (mismatches),
    .open_reports    (open_reports),
    .reports_checked (reports_checked)
  );

  // one input transaction; gaps fall between bursts unless no_gaps is set
  task automatic send_item(input cmd_e cmd, input logic [POT_W-1:0] pot);
    int unsigned gap;
    @(negedge clk_i);
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W-POT_W){1'b0}}, pot};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (cmd == CMD_TICK) begin
      period_open = 1'b1;
    end else if (cmd == CMD_STEP && period_open) begin
      period_open = 1'b0;
      reports_due++;
    end
  endtask

  function automatic logic [POT_W-1:0] pick_pot();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return POT_W'($urandom);
    endcase
  endfunction

  task automatic send_period(input int unsigned edges, input logic [POT_W-1:0] pot);
    repeat (edges) send_item($urandom_range(0, 1) ? CMD_EDGE_B : CMD_EDGE_A, POT_W'($urandom));
    send_item(CMD_TICK, POT_W'($urandom));
    send_item(CMD_STEP, pot);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // upper bits of narrow registers carry noise that the block must drop
  task automatic configure(input logic closed, input logic dir, input logic [GAIN_W-1:0] kp,
                           input logic [GAIN_W-1:0] ki, input logic [RPP_W-1:0] rpp);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[0] = closed;
    program_reg(REG_CLOSED_LOOP, word);
    word = CFG_DATA_W'($urandom);
    word[0] = dir;
    program_reg(REG_TURN_DIR, word);
    word = CFG_DATA_W'($urandom);
    word[GAIN_W-1:0] = kp;
    program_reg(REG_P_GAIN, word);
    word = CFG_DATA_W'($urandom);
    word[GAIN_W-1:0] = ki;
    program_reg(REG_I_GAIN, word);
    program_reg(REG_RPM_PER_PULSE, rpp);
    program_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                CFG_DATA_W'($urandom));
  endtask

  // stop offering, wait for every report, then let the sequencer go quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (open_reports == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : sink
    rx_mode_e    mode;
    int unsigned mode_left;
    logic [7:0]  pattern;
    mode      = RX_FREE;
    mode_left = 0;
    pattern   = '0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
          pattern   = 8'($urandom);
        end
        mode_left--;
        case (mode)
          RX_FREE:      m_axis_tready <= 1'b1;
          RX_BUSY:      m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_CONGESTED: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            m_axis_tready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      phase_start;
    int unsigned      rand_start;
    logic [RPP_W-1:0] rpp;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // open loop with reset registers
    send_item(CMD_STEP, '1);                  // no period yet: nothing comes out
    send_item(CMD_EDGE_A, '0);
    send_item(CMD_EDGE_B, '1);
    send_item(CMD_EDGE_A, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_STEP, '1);
    send_item(CMD_TICK, '1);
    send_item(CMD_STEP, '0);
    send_item(CMD_STEP, '0);                  // period already consumed
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_STEP, POT_W'(2048));
    settle();

    // closed loop: full pot saturates duty, then overspeed drives it to zero
    configure(1'b1, 1'b0, P_GAIN_RST, I_GAIN_RST, RPP_RST);
    send_item(CMD_TICK, '0);
    send_item(CMD_STEP, '1);
    settle();
    configure(1'b1, 1'b1, '1, '0, '1);
    send_item(CMD_EDGE_A, '0);
    send_item(CMD_EDGE_B, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_STEP, '0);
    settle();

    phase      = 0;
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      settle();
      case (phase)
        0: configure(1'b0, 1'b0, '0, '0, '0);
        1: configure(1'b1, 1'b1, '1, '1, RPP_W'(2000));
        default: begin
          rpp = ($urandom_range(0, 3) == 0) ? RPP_W'($urandom) : RPP_W'($urandom_range(256, 12000));
          configure(1'($urandom), 1'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), rpp);
        end
      endcase
      // the receiver holds off while items keep coming and the block backs up
      if (phase == 2) long_hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: send_item(cmd_e'($urandom_range(0, 3)), POT_W'($urandom));
          1: begin
            send_item(CMD_TICK, POT_W'($urandom));
            send_item($urandom_range(0, 1) ? CMD_TICK : CMD_STEP, pick_pot());
          end
          2: send_item(CMD_STEP, pick_pot());
          default: send_period(($urandom_range(0, 7) == 0) ? $urandom_range(13, 120) :
                               $urandom_range(0, 12), pick_pot());
        endcase
      end
      phase++;
    end
    settle();

    // one long period at full rpm_per_pulse: the speed error clamps
    configure(1'b1, 1'b0, '1, '1, '1);
    no_gaps = 1'b1;
    send_period(EDGES_PER_BIG_ERR, pick_pot());
    no_gaps = 1'b0;
    settle();

    // open loop leaves the integral alone, closed loop picks it up again
    configure(1'b0, 1'b1, '1, '1, RPP_RST);
    repeat (3) send_period($urandom_range(0, 12), pick_pot());
    settle();
    configure(1'b1, 1'b1, '1, '1, RPP_RST);
    repeat (3) send_period($urandom_range(0, 12), pick_pot());
    settle();

    $display("sent %0d input transactions over %0d random phases, %0d register writes",
             items_sent, phase, reg_writes);
    $display("checked %0d of %0d expected reports, incl. a clamped speed error",
             reports_checked, reports_due);
    if (mismatches == 0 && open_reports == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", mismatches, open_reports);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
